/* rtl/sensor_calibrate_iir_filter_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the sensor calibrate / IIR filter block
// Clocked implication checks, disabled while reset is asserted.
// ----------------------------------------------------------------------------
`ifndef SENSOR_CALIBRATE_IIR_FILTER_MACROS_SVH
`define SENSOR_CALIBRATE_IIR_FILTER_MACROS_SVH

// Same-cycle implication
`define SCIF_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define SCIF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/scif_pkg.sv */
// ----------------------------------------------------------------------------
// scif_pkg
// Shared constants, codes and filter coefficients for the sensor calibrate /
// IIR filter block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package scif_pkg;

    // Default datapath sizing
    localparam int VALUE_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF   = 20;

    // Port widths
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_W       = 32;
    localparam int OUT_TDATA_W = 2 * OUT_W;
    localparam int OUT_TUSER_W = 2;
    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 16;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_CAL_POINT_LOW  = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_CAL_POINT_HIGH = 8'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_CAL_VALUE_LOW  = 8'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_CAL_VALUE_HIGH = 8'd3;

    // Configuration reset values (1/16 degree)
    localparam logic signed [CFG_DATA_W-1:0] CAL_POINT_LOW_RST  = 16'sd0;
    localparam logic signed [CFG_DATA_W-1:0] CAL_POINT_HIGH_RST = 16'sd1600;
    localparam logic signed [CFG_DATA_W-1:0] CAL_VALUE_LOW_RST  = 16'sd0;
    localparam logic signed [CFG_DATA_W-1:0] CAL_VALUE_HIGH_RST = 16'sd1600;

    // Resolution field of the sensor configuration byte
    localparam logic [7:0] RES_MASK  = 8'h60;
    localparam logic [7:0] RES_9BIT  = 8'h00;
    localparam logic [7:0] RES_10BIT = 8'h20;
    localparam logic [7:0] RES_11BIT = 8'h40;

    // Reading is in 1/16 degree: 4 fraction bits
    localparam int RAW_FRAC = 4;

    // Filter coefficients, Q30
    localparam int COEF_W    = 34;
    localparam int COEF_FRAC = 30;
    localparam logic signed [COEF_W-1:0] COEF_B  = 34'sd982560;
    localparam logic signed [COEF_W-1:0] COEF_A1 = 34'sd2776727129;
    localparam logic signed [COEF_W-1:0] COEF_A2 = -34'sd2419567954;
    localparam logic signed [COEF_W-1:0] COEF_A3 = 34'sd708722166;

    // Filter term order: feed-forward sum, then f1, f2, f3
    localparam logic [1:0] TERM_B  = 2'd0;
    localparam logic [1:0] TERM_A1 = 2'd1;
    localparam logic [1:0] TERM_A2 = 2'd2;
    localparam logic [1:0] TERM_A3 = 2'd3;

    function automatic logic signed [COEF_W-1:0] coef_for(input logic [1:0] term);
        logic signed [COEF_W-1:0] c;
        unique case (term)
            TERM_B:  c = COEF_B;
            TERM_A1: c = COEF_A1;
            TERM_A2: c = COEF_A2;
            TERM_A3: c = COEF_A3;
            default: c = COEF_B;
        endcase
        return c;
    endfunction

endpackage

/* rtl/sensor_calibrate_iir_filter.sv */
// ----------------------------------------------------------------------------
// sensor_calibrate_iir_filter
// Temperature reading cleanup, two-point calibration and third-order
// Butterworth low-pass filter with falling-peak detection.
// ----------------------------------------------------------------------------
//  Channel  | Direction | Payload
//  s_axis   | in        | tdata: temp_low_byte, temp_high_byte, sensor_config_byte
//  m_axis   | out       | tdata: calibrated_temp, filtered_temp;
//           |           | tuser: falling_peak, calibration_fault
//  cfg      | in        | cfg_index, cfg_data (one 16-bit register per write)
//
//  One request at a time. A calibrated reading goes through the
//  one-bit-per-cycle divider and the bit-serial multiply of four filter
//  terms, all on one shared adder. A zero calibration span skips the divider.
//  s_axis_tready is low from accept until the result is loaded; a stalled
//  result blocks only the final load. cfg is always ready.
//  Reset clears control state; the first request fills all histories.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sensor_calibrate_iir_filter
    import scif_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
    parameter int FRAC_BITS   = FRAC_BITS_DEF
)(
    input  logic                   clk,
    input  logic                   rst_n,
    // Input requests
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // [7:0] temp_low_byte,
                                                  // [15:8] temp_high_byte,
                                                  // [23:16] sensor_config_byte
    // Results
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,  // [31:0] calibrated_temp,
                                                  // [63:32] filtered_temp
    output logic [OUT_TUSER_W-1:0] m_axis_tuser,  // [0] falling_peak,
                                                  // [1] calibration_fault
    // Configuration writes
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    // ------------------------------------------------------------------
    // Derived sizes
    // ------------------------------------------------------------------
    localparam int SHIFT   = FRAC_BITS - RAW_FRAC;
    localparam int NUM_W   = 32 + SHIFT;
    localparam int DVD_W   = NUM_W + 1;
    localparam int ACC_W   = (VALUE_WIDTH + 36 > DVD_W + 2) ? VALUE_WIDTH + 36 : DVD_W + 2;
    localparam int BS_W    = VALUE_WIDTH + 3;
    localparam int CNT_MAX = (DVD_W > COEF_W) ? DVD_W : COEF_W;
    localparam int CNT_W   = $clog2(CNT_MAX);
    localparam int EXT_W   = (VALUE_WIDTH > OUT_W) ? VALUE_WIDTH : OUT_W;

    localparam logic signed [ACC_W-1:0] SAT_HI =
        {{(ACC_W-VALUE_WIDTH+1){1'b0}}, {(VALUE_WIDTH-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] SAT_LO = ~SAT_HI;
    localparam logic [ACC_W-1:0] ROUND_HALF = {{(ACC_W-1){1'b0}}, 1'b1} << (COEF_FRAC - 1);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CAL_MUL,
        ST_CAL_RND,
        ST_DIV,
        ST_CAL_ADD,
        ST_SAT_X,
        ST_MAC_LOAD,
        ST_MAC,
        ST_FILT,
        ST_DONE
    } state_t;

    // Saturate an accumulator value to VALUE_WIDTH signed bits
    function automatic logic signed [VALUE_WIDTH-1:0] sat_value(
        input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] s;
        if (v > SAT_HI)
            s = SAT_HI;
        else if (v < SAT_LO)
            s = SAT_LO;
        else
            s = v;
        return s[VALUE_WIDTH-1:0];
    endfunction

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    state_t                         state_reg;
    logic                           first_pending_reg;
    logic                           out_valid_reg;
    logic [OUT_W-1:0]               out_cal_reg;
    logic [OUT_W-1:0]               out_filt_reg;
    logic                           out_peak_reg;
    logic                           out_fault_reg;

    logic signed [CFG_DATA_W-1:0]   cal_point_low_reg;
    logic signed [CFG_DATA_W-1:0]   cal_point_high_reg;
    logic signed [CFG_DATA_W-1:0]   cal_value_low_reg;
    logic signed [CFG_DATA_W-1:0]   cal_value_high_reg;

    logic signed [15:0]             reading_reg;
    logic [NUM_W-1:0]               num_reg;
    logic [15:0]                    den_reg;
    logic                           neg_reg;
    logic                           fault_reg;
    logic [DVD_W-1:0]               dvd_reg;
    logic [15:0]                    rem_reg;
    logic [CNT_W-1:0]               cnt_reg;
    logic [1:0]                     term_reg;
    logic [ACC_W-1:0]               acc_reg;
    logic [ACC_W-1:0]               mcand_reg;
    logic [COEF_W-1:0]              coef_reg;
    logic signed [VALUE_WIDTH-1:0]  samp_hist_reg [4];
    logic signed [VALUE_WIDTH-1:0]  filt_hist_reg [4];

    // ------------------------------------------------------------------
    // Handshakes
    // ------------------------------------------------------------------
    logic in_accept;
    logic out_free;
    logic out_load;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign out_load      = (state_reg == ST_DONE) && out_free;
    assign cfg_ready     = 1'b1;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_filt_reg, out_cal_reg};
    assign m_axis_tuser  = {out_fault_reg, out_peak_reg};

    // ------------------------------------------------------------------
    // Reading: clear the bits the resolution leaves undefined
    // ------------------------------------------------------------------
    logic [15:0] raw_word;
    logic [15:0] raw_masked;

    assign raw_word = s_axis_tdata[15:0];

    always_comb
    begin
        unique case (s_axis_tdata[23:16] & RES_MASK)
            RES_9BIT:  raw_masked = raw_word & ~16'h0007;
            RES_10BIT: raw_masked = raw_word & ~16'h0003;
            RES_11BIT: raw_masked = raw_word & ~16'h0001;
            default:   raw_masked = raw_word;
        endcase
    end

    // ------------------------------------------------------------------
    // Calibration differences and magnitude product
    // ------------------------------------------------------------------
    logic signed [16:0] diff_r;
    logic signed [16:0] diff_p;
    logic signed [16:0] diff_v;
    logic [15:0]        mag_r;
    logic [15:0]        mag_p;
    logic [15:0]        mag_v;
    logic [31:0]        mag_prod;

    assign diff_r   = {reading_reg[15], reading_reg}
                    - {cal_value_low_reg[15], cal_value_low_reg};
    assign diff_p   = {cal_point_high_reg[15], cal_point_high_reg}
                    - {cal_point_low_reg[15], cal_point_low_reg};
    assign diff_v   = {cal_value_high_reg[15], cal_value_high_reg}
                    - {cal_value_low_reg[15], cal_value_low_reg};
    // magnitudes never exceed 65535
    assign mag_r    = diff_r[16] ? 16'(-diff_r) : 16'(diff_r);
    assign mag_p    = diff_p[16] ? 16'(-diff_p) : 16'(diff_p);
    assign mag_v    = diff_v[16] ? 16'(-diff_v) : 16'(diff_v);
    assign mag_prod = 32'(mag_r) * 32'(mag_p);

    logic signed [ACC_W-1:0] reading_scaled;
    logic signed [ACC_W-1:0] point_low_scaled;

    assign reading_scaled   = ACC_W'(reading_reg) <<< SHIFT;
    assign point_low_scaled = ACC_W'(cal_point_low_reg) <<< SHIFT;

    // ------------------------------------------------------------------
    // Feed-forward sum x3 + x0 + 3*(x2 + x1)
    // ------------------------------------------------------------------
    logic signed [BS_W-1:0] mid_sum;
    logic signed [BS_W-1:0] ff_sum;

    assign mid_sum = BS_W'(samp_hist_reg[2]) + BS_W'(samp_hist_reg[1]);
    assign ff_sum  = BS_W'(samp_hist_reg[3]) + BS_W'(samp_hist_reg[0])
                   + mid_sum + (mid_sum <<< 1);

    // ------------------------------------------------------------------
    // Shared adder / subtractor
    // ------------------------------------------------------------------
    logic [ACC_W-1:0] alu_a;
    logic [ACC_W-1:0] alu_b;
    logic             alu_sub;
    logic [ACC_W-1:0] alu_sum;

    always_comb
    begin
        unique case (state_reg)
            ST_CAL_RND:
            begin
                alu_a   = ACC_W'(num_reg);
                alu_b   = ACC_W'(den_reg >> 1);
                alu_sub = 1'b0;
            end
            ST_DIV:
            begin
                alu_a   = ACC_W'({rem_reg, dvd_reg[DVD_W-1]});
                alu_b   = ACC_W'(den_reg);
                alu_sub = 1'b1;
            end
            ST_CAL_ADD:
            begin
                alu_a   = point_low_scaled;
                alu_b   = ACC_W'(dvd_reg);
                alu_sub = neg_reg;
            end
            ST_MAC:
            begin
                alu_a   = acc_reg;
                alu_b   = mcand_reg;
                // top coefficient bit carries negative weight
                alu_sub = (cnt_reg == CNT_W'(COEF_W - 1));
            end
            default:
            begin
                alu_a   = acc_reg;
                alu_b   = mcand_reg;
                alu_sub = 1'b0;
            end
        endcase
    end

    assign alu_sum = alu_a + (alu_sub ? ~alu_b : alu_b) + {{(ACC_W-1){1'b0}}, alu_sub};

    // Divider step result
    logic div_ge;
    assign div_ge = !alu_sum[ACC_W-1];

    // Saturated values
    logic signed [VALUE_WIDTH-1:0] x_sat;
    logic signed [VALUE_WIDTH-1:0] y_sat;
    logic signed [ACC_W-1:0]       acc_scaled;

    assign x_sat      = sat_value(acc_reg);
    assign acc_scaled = $signed(acc_reg) >>> COEF_FRAC;
    assign y_sat      = sat_value(acc_scaled);

    // Output formatting: low 32 bits of the sign-extended value
    logic signed [EXT_W-1:0] cal_ext;
    logic signed [EXT_W-1:0] filt_ext;
    logic                    peak_now;

    assign cal_ext  = EXT_W'(samp_hist_reg[0]);
    assign filt_ext = EXT_W'(filt_hist_reg[0]);
    assign peak_now = (filt_hist_reg[0] > filt_hist_reg[1])
                   && (filt_hist_reg[1] <= filt_hist_reg[2]);

    // ------------------------------------------------------------------
    // Sequencer, configuration and result registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= ST_IDLE;
            first_pending_reg  <= 1'b1;
            out_valid_reg      <= 1'b0;
            out_cal_reg        <= '0;
            out_filt_reg       <= '0;
            out_peak_reg       <= 1'b0;
            out_fault_reg      <= 1'b0;
            cal_point_low_reg  <= CAL_POINT_LOW_RST;
            cal_point_high_reg <= CAL_POINT_HIGH_RST;
            cal_value_low_reg  <= CAL_VALUE_LOW_RST;
            cal_value_high_reg <= CAL_VALUE_HIGH_RST;
        end
        else
        begin
            // configuration writes
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    CFG_CAL_POINT_LOW:  cal_point_low_reg  <= cfg_data;
                    CFG_CAL_POINT_HIGH: cal_point_high_reg <= cfg_data;
                    CFG_CAL_VALUE_LOW:  cal_value_low_reg  <= cfg_data;
                    CFG_CAL_VALUE_HIGH: cal_value_high_reg <= cfg_data;
                    default: ;
                endcase
            end

            // result taken downstream, unless a new one loads this cycle
            if (m_axis_tready && !out_load)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                ST_IDLE:
                    if (in_accept)
                        state_reg <= ST_CAL_MUL;
                ST_CAL_MUL:
                    state_reg <= (diff_v == '0) ? ST_SAT_X : ST_CAL_RND;
                ST_CAL_RND:
                    state_reg <= ST_DIV;
                ST_DIV:
                    if (cnt_reg == CNT_W'(DVD_W - 1))
                        state_reg <= ST_CAL_ADD;
                ST_CAL_ADD:
                    state_reg <= ST_SAT_X;
                ST_SAT_X:
                begin
                    first_pending_reg <= 1'b0;
                    state_reg         <= ST_MAC_LOAD;
                end
                ST_MAC_LOAD:
                    state_reg <= ST_MAC;
                ST_MAC:
                    if (cnt_reg == CNT_W'(COEF_W - 1))
                        state_reg <= (term_reg == TERM_A3) ? ST_FILT : ST_MAC_LOAD;
                ST_FILT:
                    state_reg <= ST_DONE;
                ST_DONE:
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        out_cal_reg   <= cal_ext[OUT_W-1:0];
                        out_filt_reg  <= filt_ext[OUT_W-1:0];
                        out_peak_reg  <= peak_now;
                        out_fault_reg <= fault_reg;
                        state_reg     <= ST_IDLE;
                    end
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Datapath registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
                if (in_accept)
                    reading_reg <= raw_masked;

            // magnitudes, sign of the quotient, fault
            ST_CAL_MUL:
            begin
                num_reg   <= NUM_W'(mag_prod) << SHIFT;
                den_reg   <= mag_v;
                neg_reg   <= diff_r[16] ^ diff_p[16] ^ diff_v[16];
                fault_reg <= (diff_v == '0);
                acc_reg   <= reading_scaled;
            end

            // round to nearest before the divide
            ST_CAL_RND:
            begin
                dvd_reg <= alu_sum[DVD_W-1:0];
                rem_reg <= '0;
                cnt_reg <= '0;
            end

            // restoring division, one quotient bit per cycle
            ST_DIV:
            begin
                rem_reg <= div_ge ? alu_sum[15:0] : {rem_reg[14:0], dvd_reg[DVD_W-1]};
                dvd_reg <= {dvd_reg[DVD_W-2:0], div_ge};
                cnt_reg <= cnt_reg + 1'b1;
            end

            ST_CAL_ADD:
                acc_reg <= alu_sum;

            // store sample, age histories, seed the rounding constant
            ST_SAT_X:
            begin
                samp_hist_reg[0] <= x_sat;
                if (first_pending_reg)
                begin
                    samp_hist_reg[1] <= x_sat;
                    samp_hist_reg[2] <= x_sat;
                    samp_hist_reg[3] <= x_sat;
                    filt_hist_reg[1] <= x_sat;
                    filt_hist_reg[2] <= x_sat;
                    filt_hist_reg[3] <= x_sat;
                end
                else
                begin
                    samp_hist_reg[1] <= samp_hist_reg[0];
                    samp_hist_reg[2] <= samp_hist_reg[1];
                    samp_hist_reg[3] <= samp_hist_reg[2];
                    filt_hist_reg[1] <= filt_hist_reg[0];
                    filt_hist_reg[2] <= filt_hist_reg[1];
                    filt_hist_reg[3] <= filt_hist_reg[2];
                end
                acc_reg  <= ROUND_HALF;
                term_reg <= TERM_B;
            end

            ST_MAC_LOAD:
            begin
                if (term_reg == TERM_B)
                    mcand_reg <= ACC_W'(ff_sum);
                else
                    mcand_reg <= ACC_W'(filt_hist_reg[term_reg]);
                coef_reg <= coef_for(term_reg);
                cnt_reg  <= '0;
            end

            // bit-serial multiply-accumulate
            ST_MAC:
            begin
                if (coef_reg[0])
                    acc_reg <= alu_sum;
                coef_reg  <= coef_reg >> 1;
                mcand_reg <= mcand_reg << 1;
                cnt_reg   <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(COEF_W - 1))
                    term_reg <= term_reg + 1'b1;
            end

            ST_FILT:
                filt_hist_reg[0] <= y_sat;

            default: ;
        endcase
    end

endmodule

/* rtl/scif_checker.sv */
// ----------------------------------------------------------------------------
// scif_checker
// Port-level checks for sensor_calibrate_iir_filter, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "sensor_calibrate_iir_filter_macros.svh"

module scif_checker
    import scif_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   s_axis_tvalid,
    input logic                   s_axis_tready,
    input logic                   m_axis_tvalid,
    input logic                   m_axis_tready,
    input logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input logic [OUT_TUSER_W-1:0] m_axis_tuser,
    input logic                   cfg_ready
);

    // Stalled result holds
    `SCIF_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled result changed")

    // One request in flight: busy right after an accept
    `SCIF_ASSERT_NEXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready, "input ready right after accept")

    // A new result appears only as the block goes back to idle
    `SCIF_ASSERT_SAME(a_result_at_idle, $rose(m_axis_tvalid), s_axis_tready && $past(!s_axis_tready), "result without finished request")

    // Configuration is never back-pressured
    `SCIF_ASSERT_SAME(a_cfg_ready, 1'b1, cfg_ready, "configuration port stalled")

endmodule

bind sensor_calibrate_iir_filter scif_checker u_scif_checker (.*);

/* tb/tb_sensor_calibrate_iir_filter.sv */
// ----------------------------------------------------------------------------
// tb_sensor_calibrate_iir_filter
// Self-checking bench for the calibrate / low-pass filter block. Readings are
// queued by phase and fed through a stream driver with random gaps. A
// bit-exact predictor runs on every accepted reading, and the monitor checks
// each result against the oldest prediction. Calibration is rewritten between
// phases: identity, saturating slope, zero span, inverted and random settings.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_sensor_calibrate_iir_filter;
    import scif_pkg::*;

    localparam int    CAL_SHIFT       = FRAC_BITS_DEF - RAW_FRAC;
    localparam int    RANDOM_PHASES   = 8;
    localparam int    PHASE_READINGS  = 235;
    localparam int    HOLD_CYCLES     = 700;
    localparam int    SETTLE_CYCLES   = 250;
    localparam longint TIMEOUT_NS     = 12_000_000;

    // Write indexes past the last register
    localparam logic [CFG_INDEX_W-1:0] CFG_UNMAPPED_FIRST = 8'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_UNMAPPED_LAST  = 8'd255;

    // Butterworth taps, Q30
    localparam logic signed [79:0] TAP_B      = 80'sd982560;
    localparam logic signed [79:0] TAP_A1     = 80'sd2776727129;
    localparam logic signed [79:0] TAP_A2     = -80'sd2419567954;
    localparam logic signed [79:0] TAP_A3     = 80'sd708722166;
    localparam logic signed [79:0] ROUND_HALF = 80'sd536870912;

    typedef struct packed {
        logic signed [31:0] calibrated;
        logic signed [31:0] filtered;
        logic               peak;
        logic               fault;
    } reading_result_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic [OUT_TUSER_W-1:0] m_axis_tuser;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    // Stimulus and scoreboard
    logic [IN_TDATA_W-1:0] pending_readings[$];
    reading_result_t       expected_readings[$];
    int                    queued_count = 0;
    int                    accepted_count = 0;
    bit                    run_failed = 1'b0;

    // Handshake bookkeeping shared between monitor and drivers
    bit in_taken = 1'b0;
    bit out_taken = 1'b0;
    bit send_idle = 1'b1;
    bit recv_idle = 1'b1;
    int send_wait = 0;
    int recv_wait = 0;
    int hold_requests = 0;
    int hold_served = 0;
    int hold_left = 0;

    // Predictor state
    logic signed [15:0] cal_pl = CAL_POINT_LOW_RST;
    logic signed [15:0] cal_ph = CAL_POINT_HIGH_RST;
    logic signed [15:0] cal_vl = CAL_VALUE_LOW_RST;
    logic signed [15:0] cal_vh = CAL_VALUE_HIGH_RST;
    logic signed [31:0] sample_hist[4] = '{default: '0};
    logic signed [31:0] filter_hist[4] = '{default: '0};
    bit                 first_pending = 1'b1;

    sensor_calibrate_iir_filter u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    // Saturate to the signed 32-bit fixed-point range
    function automatic logic signed [31:0] clamp_q20(input logic signed [79:0] v);
        if (v > 80'sd2147483647)
            return 32'sh7FFFFFFF;
        if (v < -80'sd2147483648)
            return 32'sh80000000;
        return v[31:0];
    endfunction

    // Calibrate one reading, advance both histories, run the filter
    function automatic reading_result_t calibrate_and_filter(
        input logic [IN_TDATA_W-1:0] word);
        logic [15:0]        raw;
        logic [7:0]         res;
        logic signed [63:0] r, dr, dp, dd, x0;
        logic [63:0]        mdr, mdp, num, den, q;
        logic signed [79:0] feed, acc;
        logic               neg;
        reading_result_t    o;
        raw = word[15:0];
        res = word[23:16] & RES_MASK;
        // clear the bits that a reduced resolution leaves undefined
        if (res == RES_9BIT)
            raw[2:0] = 3'b000;
        else if (res == RES_10BIT)
            raw[1:0] = 2'b00;
        else if (res == RES_11BIT)
            raw[0] = 1'b0;
        r  = 64'($signed(raw));
        dr = r - 64'(cal_vl);
        dp = 64'(cal_ph) - 64'(cal_pl);
        dd = 64'(cal_vh) - 64'(cal_vl);
        o.fault = (dd == 0);
        if (o.fault)
            x0 = r * 64'sd65536;
        else
        begin
            mdr = (dr < 0) ? -dr : dr;
            mdp = (dp < 0) ? -dp : dp;
            den = (dd < 0) ? -dd : dd;
            num = (mdr * mdp) << CAL_SHIFT;
            q   = (num + den / 64'd2) / den;
            neg = ((dr < 0) != (dp < 0)) != (dd < 0);
            if (dr == 0 || dp == 0)
                neg = 1'b0;
            x0 = neg ? -$signed(q) : $signed(q);
            x0 = x0 + 64'(cal_pl) * 64'sd65536;
        end
        o.calibrated = clamp_q20(80'(x0));

        for (int i = 3; i > 0; i--)
            sample_hist[i] = sample_hist[i-1];
        sample_hist[0] = o.calibrated;
        // first reading after reset primes both histories
        if (first_pending)
        begin
            for (int i = 1; i < 4; i++)
                sample_hist[i] = o.calibrated;
            for (int i = 0; i < 4; i++)
                filter_hist[i] = o.calibrated;
            first_pending = 1'b0;
        end
        for (int i = 3; i > 0; i--)
            filter_hist[i] = filter_hist[i-1];

        feed = 80'(sample_hist[3]) + 80'(sample_hist[0])
             + 80'sd3 * (80'(sample_hist[2]) + 80'(sample_hist[1]));
        acc  = TAP_B * feed + TAP_A1 * 80'(filter_hist[1]) + TAP_A2 * 80'(filter_hist[2])
             + TAP_A3 * 80'(filter_hist[3]);
        o.filtered = clamp_q20((acc + ROUND_HALF) >>> 30);
        filter_hist[0] = o.filtered;
        o.peak = (filter_hist[0] > filter_hist[1]) && (filter_hist[1] <= filter_hist[2]);
        return o;
    endfunction

    // Monitor: track config writes, predict accepted readings, check results
    always @(posedge clk)
    begin
        reading_result_t want;
        if (rst_n)
        begin
            in_taken  <= s_axis_tvalid && s_axis_tready;
            out_taken <= m_axis_tvalid && m_axis_tready;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_CAL_POINT_LOW:  cal_pl = cfg_data;
                    CFG_CAL_POINT_HIGH: cal_ph = cfg_data;
                    CFG_CAL_VALUE_LOW:  cal_vl = cfg_data;
                    CFG_CAL_VALUE_HIGH: cal_vh = cfg_data;
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                expected_readings.push_back(calibrate_and_filter(s_axis_tdata));
                accepted_count++;
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_readings.size() == 0)
                begin
                    $error("result with no reading pending: tdata %h tuser %b",
                           m_axis_tdata, m_axis_tuser);
                    run_failed = 1'b1;
                end
                else
                begin
                    want = expected_readings.pop_front();
                    if (m_axis_tdata[31:0] !== want.calibrated)
                    begin
                        $error("calibrated_temp: expected %0d, got %0d",
                               want.calibrated, $signed(m_axis_tdata[31:0]));
                        run_failed = 1'b1;
                    end
                    if (m_axis_tdata[63:32] !== want.filtered)
                    begin
                        $error("filtered_temp: expected %0d, got %0d",
                               want.filtered, $signed(m_axis_tdata[63:32]));
                        run_failed = 1'b1;
                    end
                    if (m_axis_tuser[0] !== want.peak)
                    begin
                        $error("falling_peak: expected %0b, got %0b",
                               want.peak, m_axis_tuser[0]);
                        run_failed = 1'b1;
                    end
                    if (m_axis_tuser[1] !== want.fault)
                    begin
                        $error("calibration_fault: expected %0b, got %0b",
                               want.fault, m_axis_tuser[1]);
                        run_failed = 1'b1;
                    end
                end
            end
        end
    end

    // Reading driver: one request per pending word, random gap after each while send_idle is set
    always @(negedge clk)
    begin
        if (rst_n && (!s_axis_tvalid || in_taken))
        begin
            if (in_taken)
                send_wait = send_idle ? $urandom_range(0, 8) : 0;
            if (send_wait > 0)
            begin
                s_axis_tvalid <= 1'b0;
                send_wait--;
            end
            else if (pending_readings.size() != 0)
            begin
                s_axis_tdata  <= pending_readings.pop_front();
                s_axis_tvalid <= 1'b1;
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    // Result sink: random stall per result while recv_idle is set, plus long hold-offs on request
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (out_taken)
                recv_wait = recv_idle ? $urandom_range(0, 8) : 0;
            if (hold_served != hold_requests)
            begin
                hold_left   = HOLD_CYCLES;
                hold_served = hold_requests;
            end
            if (hold_left > 0)
            begin
                m_axis_tready <= 1'b0;
                hold_left--;
            end
            else if (recv_wait > 0)
            begin
                m_axis_tready <= 1'b0;
                if (m_axis_tvalid)
                    recv_wait--;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    task automatic queue_reading(input logic [15:0] raw, input logic [7:0] sensor_cfg);
        pending_readings.push_back({sensor_cfg, raw});
        queued_count++;
    endtask

    task automatic wait_until_drained();
        while (accepted_count != queued_count || expected_readings.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_cal_register(input logic [CFG_INDEX_W-1:0] index,
                                      input logic [CFG_DATA_W-1:0]  value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    // All four registers plus one write to an unmapped index
    task automatic write_calibration(input logic [15:0] pl, input logic [15:0] ph,
                                     input logic [15:0] vl, input logic [15:0] vh,
                                     input logic [CFG_INDEX_W-1:0] junk_index,
                                     input logic [15:0] junk_data);
        write_cal_register(CFG_CAL_POINT_LOW, pl);
        write_cal_register(junk_index, junk_data);
        write_cal_register(CFG_CAL_POINT_HIGH, ph);
        write_cal_register(CFG_CAL_VALUE_LOW, vl);
        write_cal_register(CFG_CAL_VALUE_HIGH, vh);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [15:0] extreme_word();
        case ($urandom_range(0, 3))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'h0000;
            default: return 16'hFFFF;
        endcase
    endfunction

    // Stimulus sequence
    initial
    begin
        int kind, pl, ph, vl, vh, walk_temp;
        logic [15:0] raw;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Identity calibration from reset: first reading, word extremes,
        // every resolution, unused config bits set
        queue_reading(16'h0000, 8'h60);
        queue_reading(16'h7FFF, 8'h60);
        queue_reading(16'h8000, 8'h60);
        queue_reading(16'hFFFF, 8'h60);
        queue_reading(16'h07FF, 8'h00);
        queue_reading(16'h07FF, 8'h20);
        queue_reading(16'h07FF, 8'h40);
        queue_reading(16'h07FF, 8'h9F);
        queue_reading(16'h07FF, 8'hFF);
        queue_reading(16'h0150, 8'h7F);
        wait_until_drained();

        // Steep slope: saturates both ways, zero offset lands on the low point
        write_calibration(16'h8000, 16'h7FFF, 16'h0000, 16'h0001,
                          CFG_UNMAPPED_FIRST, 16'hA5A5);
        queue_reading(16'h0000, 8'h60);
        queue_reading(16'h0010, 8'h60);
        queue_reading(16'hFFF0, 8'h60);
        queue_reading(16'h7FFF, 8'h60);
        queue_reading(16'h8000, 8'h60);
        wait_until_drained();

        // Zero span: reading passes uncalibrated with the fault flag
        write_calibration(16'h7FFF, 16'h8000, 16'h1234, 16'h1234,
                          CFG_UNMAPPED_LAST, 16'h5A5A);
        queue_reading(16'h7FFF, 8'h60);
        queue_reading(16'h8000, 8'h60);
        queue_reading(16'h1234, 8'h60);
        wait_until_drained();

        // Random phases: new calibration each, mostly smooth temperature walks
        walk_temp = 400;
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            kind = $urandom_range(0, 4);
            case (kind)
                0:
                begin
                    pl = $urandom_range(0, 400);
                    ph = $urandom_range(1200, 1800);
                    vl = pl + $urandom_range(0, 80) - 40;
                    vh = ph + $urandom_range(0, 80) - 40;
                end
                1:
                begin
                    pl = $urandom_range(0, 65535);
                    ph = $urandom_range(0, 65535);
                    vl = $urandom_range(0, 65535);
                    vh = $urandom_range(0, 65535);
                end
                2:
                begin
                    pl = $urandom_range(0, 65535);
                    ph = $urandom_range(0, 65535);
                    vl = $urandom_range(0, 65535);
                    vh = vl;
                end
                3:
                begin
                    pl = int'(extreme_word());
                    ph = int'(extreme_word());
                    vl = int'(extreme_word());
                    vh = int'(extreme_word());
                end
                default:
                begin
                    pl = $urandom_range(0, 400);
                    ph = $urandom_range(1200, 1800);
                    vl = 1600 + $urandom_range(0, 200);
                    vh = $urandom_range(0, 200);
                end
            endcase
            write_calibration(pl[15:0], ph[15:0], vl[15:0], vh[15:0],
                              8'($urandom_range(CFG_UNMAPPED_FIRST, CFG_UNMAPPED_LAST)),
                              16'($urandom_range(0, 65535)));
            send_idle = (phase % 2 == 0);
            recv_idle = (phase % 4 < 2);
            for (int n = 0; n < PHASE_READINGS; n++)
            begin
                if ($urandom_range(0, 9) < 6)
                begin
                    walk_temp = walk_temp + $urandom_range(0, 32) - 16;
                    if ($urandom_range(0, 49) == 0)
                        walk_temp = walk_temp + $urandom_range(0, 800) - 400;
                    if (walk_temp > 2000)
                        walk_temp = 2000;
                    if (walk_temp < -880)
                        walk_temp = -880;
                    raw = walk_temp[15:0];
                end
                else
                    raw = 16'($urandom_range(0, 65535));
                queue_reading(raw, 8'($urandom_range(0, 255)));
            end
            // hold results back long enough for the input side to stall
            if (phase == 1 || phase == 5)
                hold_requests++;
            wait_until_drained();
        end

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (expected_readings.size() != 0)
        begin
            $error("%0d results never arrived", expected_readings.size());
            run_failed = 1'b1;
        end
        if (!run_failed)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // Watchdog
    initial
    begin
        #(TIMEOUT_NS);
        $display("simulation failed");
        $finish;
    end

endmodule

/* files.f */
+incdir+rtl
rtl/scif_pkg.sv
rtl/sensor_calibrate_iir_filter.sv
rtl/scif_checker.sv
tb/tb_sensor_calibrate_iir_filter.sv
